/* hdl/pwsfd_pkg.sv */
// ---------------------------------------------------------------------------
// pwsfd_pkg
// Shared types and constants for the pulse-width sensor frame decoder.
// ---------------------------------------------------------------------------
package pwsfd_pkg;

  localparam int CFG_WIDTH       = 12;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int SLOT_WIDTH      = 3;
  localparam int DIST_WIDTH      = 8;

  localparam int COUNT_WIDTH_DEFAULT = 12;
  localparam int FRAME_BYTES_DEFAULT = 6;

  localparam logic [CFG_WIDTH-1:0] SYNC_MIN_RESET = 12'd900;
  localparam logic [CFG_WIDTH-1:0] ONE_MAX_RESET  = 12'd150;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SYNC_MIN = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ONE_MAX  = 2'd1;

  localparam logic [DIST_WIDTH-1:0] NO_OBJECT_MIN  = 8'hF0;
  localparam logic [DIST_WIDTH-1:0] NO_OBJECT_CODE = 8'hFF;
  localparam logic [DIST_WIDTH-1:0] DM_TO_CM       = 8'd10;

  // classified low pulse, seen at a rising edge
  typedef struct packed {
    logic rise;
    logic sync;
    logic bit_val;
  } pulse_t;

  typedef struct packed {
    logic [SLOT_WIDTH-1:0] sensor_slot;
    logic [DIST_WIDTH-1:0] distance_cm;
    logic                  framing_error;
    logic                  frame_end;
  } result_t;

endpackage

/* hdl/pwsfd_low_counter.sv */
// ---------------------------------------------------------------------------
// pwsfd_low_counter
// Counts low ticks on the line and classifies each low pulse at its rising
// edge as sync gap, bit one or bit zero.
// ---------------------------------------------------------------------------
module pwsfd_low_counter #(
  parameter int COUNT_WIDTH = pwsfd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           level,
  input  logic [pwsfd_pkg::CFG_WIDTH-1:0] sync_min_ticks,
  input  logic [pwsfd_pkg::CFG_WIDTH-1:0] one_max_ticks,
  output pwsfd_pkg::pulse_t              pulse
);
  import pwsfd_pkg::*;

  localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  logic                   previous_level;
  logic [COUNT_WIDTH-1:0] low_ticks;
  logic [COUNT_WIDTH-1:0] low_ticks_next;
  logic [CMP_WIDTH-1:0]   ticks_ext;

  assign ticks_ext = CMP_WIDTH'(low_ticks);

  always_comb begin
    low_ticks_next = low_ticks;
    if (!level) begin
      if (previous_level) begin
        low_ticks_next = COUNT_WIDTH'(1);
      end else if (low_ticks != '1) begin
        low_ticks_next = low_ticks + COUNT_WIDTH'(1);
      end
    end
  end

  always_comb begin
    pulse.rise    = level && !previous_level;
    pulse.sync    = ticks_ext > CMP_WIDTH'(sync_min_ticks);
    pulse.bit_val = ticks_ext < CMP_WIDTH'(one_max_ticks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b1;
      low_ticks      <= '1;
    end else if (step) begin
      previous_level <= level;
      low_ticks      <= low_ticks_next;
    end
  end

endmodule

/* hdl/pwsfd_byte_assembler.sv */
// ---------------------------------------------------------------------------
// pwsfd_byte_assembler
// Shifts decoded bits into bytes, tracks the sensor slot within a frame and
// forms one result per finished byte or per sync that breaks a byte.
// ---------------------------------------------------------------------------
module pwsfd_byte_assembler #(
  parameter int FRAME_BYTES = pwsfd_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pwsfd_pkg::pulse_t   pulse,
  output logic                push,
  output pwsfd_pkg::result_t  result
);
  import pwsfd_pkg::*;

  logic [2:0]            bit_phase;
  logic [2:0]            bit_phase_next;
  logic [7:0]            shift_byte;
  logic [7:0]            shift_byte_next;
  logic [SLOT_WIDTH-1:0] byte_slot;
  logic [SLOT_WIDTH-1:0] byte_slot_next;
  logic [7:0]            shifted;
  logic [SLOT_WIDTH:0]   slot_inc;
  logic                  last;

  assign shifted  = {shift_byte[6:0], pulse.bit_val};
  assign slot_inc = {1'b0, byte_slot} + (SLOT_WIDTH + 1)'(1);
  assign last     = slot_inc >= (SLOT_WIDTH + 1)'(FRAME_BYTES);

  always_comb begin
    bit_phase_next  = bit_phase;
    shift_byte_next = shift_byte;
    byte_slot_next  = byte_slot;
    push            = 1'b0;
    result          = '0;
    if (step && pulse.rise) begin
      if (pulse.sync) begin
        push                 = bit_phase != 3'd0;
        result.framing_error = 1'b1;
        bit_phase_next       = '0;
        shift_byte_next      = '0;
        byte_slot_next       = '0;
      end else begin
        bit_phase_next  = bit_phase + 3'd1;
        shift_byte_next = shifted;
        if (bit_phase == 3'd7) begin
          push               = 1'b1;
          result.sensor_slot = byte_slot;
          result.distance_cm = (shifted >= NO_OBJECT_MIN) ? NO_OBJECT_CODE
                                                          : 8'(shifted * DM_TO_CM);
          result.frame_end   = last;
          byte_slot_next     = last ? '0 : slot_inc[SLOT_WIDTH-1:0];
          shift_byte_next    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_phase  <= '0;
      shift_byte <= '0;
      byte_slot  <= '0;
    end else begin
      bit_phase  <= bit_phase_next;
      shift_byte <= shift_byte_next;
      byte_slot  <= byte_slot_next;
    end
  end

  a_slot_in_frame: assert property (@(posedge clk) disable iff (rst)
    {1'b0, byte_slot} < (SLOT_WIDTH + 1)'(FRAME_BYTES))
    else $error("byte slot past frame length");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (push && result.framing_error) |->
      (result.sensor_slot == '0 && result.distance_cm == '0 && !result.frame_end))
    else $error("framing error result carries data");

  a_push_on_rise: assert property (@(posedge clk) disable iff (rst)
    push |-> (step && pulse.rise))
    else $error("result without rising edge");

endmodule

/* hdl/pwsfd_out_buffer.sv */
// ---------------------------------------------------------------------------
// pwsfd_out_buffer
// Output register with one skid entry that holds a result pushed while the
// receiver stalls.
// ---------------------------------------------------------------------------
module pwsfd_out_buffer (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pwsfd_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output pwsfd_pkg::result_t out_data
);
  import pwsfd_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall && push))
    else $error("skid filled without stalled output");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into full buffer");

endmodule

/* hdl/pulse_width_sensor_frame_decoder_unit.sv */
// ---------------------------------------------------------------------------
// pulse_width_sensor_frame_decoder_unit
// Decodes the pulse-width line of a six-channel parking sensor into one
// distance result per sensor byte, with framing errors on early sync.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  line_level
//   output   out_valid/out_stall  sensor_slot, distance_cm, framing_error,
//                                 frame_end
//   config   cfg_we               cfg_index, cfg_data
//
// one sample per cycle while in_stall is low; a sample passes the input
// register, then its result is decoded into the output register
// in_stall rises only when the output is stalled and the skid entry is full
// rst restores thresholds 900 and 150, idle-high line and saturated count
// ---------------------------------------------------------------------------
module pulse_width_sensor_frame_decoder_unit #(
  parameter int COUNT_WIDTH = pwsfd_pkg::COUNT_WIDTH_DEFAULT,
  parameter int FRAME_BYTES = pwsfd_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pwsfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [pwsfd_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  line_level,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [pwsfd_pkg::SLOT_WIDTH-1:0]      sensor_slot,
  output logic [pwsfd_pkg::DIST_WIDTH-1:0]      distance_cm,
  output logic                                  framing_error,
  output logic                                  frame_end
);
  import pwsfd_pkg::*;

  logic [CFG_WIDTH-1:0] sync_min_ticks;
  logic [CFG_WIDTH-1:0] one_max_ticks;
  logic                 sample_valid;
  logic                 sample_level;
  logic                 advance;
  logic                 step;
  logic                 full;
  logic                 push;
  pulse_t               pulse;
  result_t              result;
  result_t              out_data;

  assign in_stall = full;
  assign advance  = !full;
  assign step     = advance && sample_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min_ticks <= SYNC_MIN_RESET;
      one_max_ticks  <= ONE_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_MIN: sync_min_ticks <= cfg_data;
        REG_ONE_MAX:  one_max_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (advance) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_level <= line_level;
    end
  end

  pwsfd_low_counter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counter (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .level          (sample_level),
    .sync_min_ticks (sync_min_ticks),
    .one_max_ticks  (one_max_ticks),
    .pulse          (pulse)
  );

  pwsfd_byte_assembler #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_assembler (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .pulse  (pulse),
    .push   (push),
    .result (result)
  );

  pwsfd_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign sensor_slot   = out_data.sensor_slot;
  assign distance_cm   = out_data.distance_cm;
  assign framing_error = out_data.framing_error;
  assign frame_end     = out_data.frame_end;

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-width sensor frame decoder. Line samples
// go in through the valid/stall channel; a scoreboard tracks the decoder
// state (low count, bit phase, shift byte, slot) and checks every distance
// or framing-error result in order. Thresholds are reprogrammed between
// phases, covering default, extreme and random settings, with bursty input
// and a receiver that stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb_top;

  import pwsfd_pkg::*;

  localparam int COUNT_W    = COUNT_WIDTH_DEFAULT;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_TICKS = 400;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 2'd3;

  class sensor_frame_scoreboard;
    logic [CFG_WIDTH-1:0]  sync_min;
    logic [CFG_WIDTH-1:0]  one_max;
    logic                  prev_level;
    logic [COUNT_W-1:0]    low_count;
    logic [2:0]            bit_pos;
    logic [7:0]            shreg;
    logic [SLOT_WIDTH-1:0] slot;
    result_t               pending_results[$];
    int                    errors;
    int                    results_seen;

    function new();
      sync_min     = SYNC_MIN_RESET;
      one_max      = ONE_MAX_RESET;
      prev_level   = 1'b1;
      low_count    = '1;
      bit_pos      = '0;
      shreg        = '0;
      slot         = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
      if (idx == REG_SYNC_MIN) sync_min = val;
      else if (idx == REG_ONE_MAX) one_max = val;
    endfunction

    function void note_line_sample(logic lvl);
      result_t r;
      logic    bitv;
      if (!lvl) begin
        if (prev_level) low_count = 1;
        else if (low_count != '1) low_count = low_count + 1'b1;
      end else if (!prev_level) begin
        if (low_count > sync_min) begin
          // sync gap: mid-byte arrival is a framing error
          if (bit_pos != 0) begin
            r = '0;
            r.framing_error = 1'b1;
            pending_results.push_back(r);
          end
          slot    = '0;
          bit_pos = '0;
          shreg   = '0;
        end else begin
          bitv    = low_count < one_max;
          shreg   = {shreg[6:0], bitv};
          bit_pos = bit_pos + 1'b1;
          if (bit_pos == 0) begin
            r = '0;
            r.sensor_slot = slot;
            r.distance_cm = (shreg >= NO_OBJECT_MIN) ? NO_OBJECT_CODE
                                                     : 8'(shreg * DM_TO_CM);
            r.frame_end   = (int'(slot) + 1 >= FRAME_BYTES_DEFAULT);
            pending_results.push_back(r);
            slot  = r.frame_end ? '0 : slot + 1'b1;
            shreg = '0;
          end
        end
      end
      prev_level = lvl;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_distance_result(result_t got);
      result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result slot=%0d dist=%0d ferr=%0b end=%0b",
                         got.sensor_slot, got.distance_cm, got.framing_error,
                         got.frame_end));
        return;
      end
      want = pending_results.pop_front();
      if (got.sensor_slot !== want.sensor_slot || got.distance_cm !== want.distance_cm ||
          got.framing_error !== want.framing_error || got.frame_end !== want.frame_end)
        report($sformatf({"result mismatch: exp slot=%0d dist=%0d ferr=%0b end=%0b, ",
                          "got slot=%0d dist=%0d ferr=%0b end=%0b"},
                         want.sensor_slot, want.distance_cm, want.framing_error,
                         want.frame_end, got.sensor_slot, got.distance_cm,
                         got.framing_error, got.frame_end));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       line_level;
  logic                       out_valid;
  logic                       out_stall;
  logic [SLOT_WIDTH-1:0]      sensor_slot;
  logic [DIST_WIDTH-1:0]      distance_cm;
  logic                       framing_error;
  logic                       frame_end;

  sensor_frame_scoreboard sb;

  int samples_sent = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;
  int rx_cycle     = 0;
  int idle_cycles  = 0;
  int thr_sync     = SYNC_MIN_RESET;
  int thr_one      = ONE_MAX_RESET;

  pulse_width_sensor_frame_decoder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .line_level    (line_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sensor_slot   (sensor_slot),
    .distance_cm   (distance_cm),
    .framing_error (framing_error),
    .frame_end     (frame_end)
  );

  always #1 clk = ~clk;

  // transfer monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_line_sample(line_level);
      if (out_valid && !out_stall)
        sb.check_distance_result(result_t'{sensor_slot, distance_cm, framing_error,
                                           frame_end});
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("pulse_width_sensor_frame_decoder_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_TICKS) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else begin
        rx_cycle++;
        case ((rx_cycle / 300) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 40);
          2: out_stall <= ((rx_cycle % 5) < 2);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  function automatic int pick_high();
    if ($urandom_range(0, 9) == 0) return $urandom_range(3, 12);
    return $urandom_range(1, 2);
  endfunction

  task automatic drive_sample(input logic lvl);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    line_level <= lvl;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic drive_level(input logic lvl, input int n);
    repeat (n) drive_sample(lvl);
  endtask

  task automatic send_pulse(input int low_len, input int high_len);
    drive_level(1'b0, low_len);
    drive_level(1'b1, high_len);
  endtask

  task automatic send_data_bit(input logic b);
    if (b) send_pulse($urandom_range(1, thr_one - 1), pick_high());
    else send_pulse($urandom_range(thr_one, thr_sync), pick_high());
  endtask

  task automatic send_byte(input logic [7:0] code);
    for (int i = 7; i >= 0; i--) send_data_bit(code[i]);
  endtask

  task automatic send_sync();
    send_pulse($urandom_range(thr_sync + 1, thr_sync + 5), pick_high());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int s, input int o);
    drain();
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 12'($urandom));
    write_reg(REG_SYNC_MIN, 12'(s));
    write_reg(REG_ONE_MAX, 12'(o));
    cfg_we   <= 1'b0;
    thr_sync = s;
    thr_one  = o;
  endtask

  function automatic logic [7:0] rand_code();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'hF0, 8'hFF));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_phase(input bit first);
    int s;
    int frames;
    int nbytes;
    if (first) begin
      s = 6;
      set_thresholds(s, 3);
      gaps_on  = 1'b0;
      hold_req = 1'b1;
      frames   = 1;
    end else begin
      s = $urandom_range(3, 12);
      set_thresholds(s, $urandom_range(2, s));
      gaps_on = ($urandom_range(0, 3) != 0);
      frames  = $urandom_range(1, 2);
    end
    repeat (frames) begin
      case (first ? 9 : $urandom_range(0, 9))
        0: repeat ($urandom_range(20, 60)) drive_sample(1'($urandom_range(0, 1)));
        1: begin
          // frame cut short by an early sync
          send_sync();
          repeat ($urandom_range(0, 5)) send_byte(rand_code());
          repeat ($urandom_range(1, 7)) send_data_bit(1'($urandom_range(0, 1)));
          send_sync();
        end
        2: begin
          send_sync();
          nbytes = $urandom_range(7, 9);
          repeat (nbytes) send_byte(rand_code());
        end
        default: begin
          send_sync();
          repeat (FRAME_BYTES_DEFAULT) send_byte(rand_code());
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] codes [7];
    int         exact_lows [8];
    int         phases;

    sb = new();
    codes      = '{8'hFF, 8'hF0, 8'hEF, 8'h00, 8'h19, 8'h1A, 8'h80};
    exact_lows = '{3, 4, 8, 1, 3, 4, 8, 1};
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_SYNC_MIN;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    line_level <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds, equality on the one threshold
    drive_level(1'b1, 3);
    send_pulse(150, 2);
    send_pulse(149, 2);

    // small thresholds, no-object codes, wrap, frame end, slot restart
    set_thresholds(8, 4);
    drive_level(1'b1, 3);
    send_sync();
    foreach (codes[i]) send_byte(codes[i]);
    foreach (exact_lows[i]) send_pulse(exact_lows[i], pick_high());
    repeat (3) send_data_bit(1'b1);
    send_pulse(9, 2);
    send_pulse(9, 2);

    // every low is a sync
    set_thresholds(0, 0);
    repeat (80) drive_sample(1'($urandom_range(0, 1)));

    // nothing is a sync
    set_thresholds(4095, 4095);
    send_pulse(40, 2);
    repeat (7) send_pulse($urandom_range(1, 3), pick_high());

    // every bit a zero
    set_thresholds(4095, 0);
    repeat (8) send_pulse($urandom_range(1, 10), pick_high());

    phases = 0;
    while (samples_sent < 1300) begin
      random_phase(phases == 0);
      phases++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("pulse_width_sensor_frame_decoder_unit test passed");
    else
      $display("pulse_width_sensor_frame_decoder_unit test failed");
    $finish;
  end

endmodule
